// ===== hw/rtl/pcnms_pkg.sv =====
// shared types and constants for the per-class box suppression block
package pcnms_pkg;

  localparam int MAX_BOXES_DEF   = 64;
  localparam int MAX_CLASSES_DEF = 16;

  localparam int COORD_W = 16;
  localparam int SCORE_W = 16;
  localparam int CLASS_W = 4;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] IOU_THR_RESET     = 16'd29491;
  localparam logic [4:0]  CLASS_COUNT_RESET = 5'd1;

  localparam logic [CFG_IDX_W-1:0] REG_IOU_THR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 2'd1;

  // one stored box, class in the top bits
  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] score;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // status back from the overlap unit
  typedef struct packed {
    logic done;
    logic suppress;
  } iou_res_t;

endpackage

// ===== hw/rtl/pcnms_ram.sv =====
// generic single write port ram with registered read
module pcnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/pcnms_iou.sv =====
// overlap test of two boxes on one shared multiplier, one test at a time
module pcnms_iou (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  pcnms_pkg::box_t     box_a,
  input  pcnms_pkg::box_t     box_b,
  input  logic [15:0]         thr,
  output pcnms_pkg::iou_res_t res
);

  typedef enum logic [7:0] {
    I_IDLE = 8'b0000_0001,
    I_OV   = 8'b0000_0010,
    I_AA   = 8'b0000_0100,
    I_AB   = 8'b0000_1000,
    I_UNI  = 8'b0001_0000,
    I_LO   = 8'b0010_0000,
    I_HI   = 8'b0100_0000,
    I_CMP  = 8'b1000_0000
  } iou_state_t;

  iou_state_t state;

  logic signed [16:0] ow, oh, wa, ha, wb, hb;
  logic signed [35:0] ov, aa, ab, uni, plo, phi;
  logic [15:0] min_r, max_l, min_b, max_t;
  logic signed [17:0] mul_x, mul_y;
  logic signed [35:0] mul_p;
  logic [51:0] lhs, rhs;
  logic no_ov, no_uni;

  assign min_r = (box_a.right < box_b.right) ? box_a.right : box_b.right;
  assign max_l = (box_a.left > box_b.left) ? box_a.left : box_b.left;
  assign min_b = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
  assign max_t = (box_a.top > box_b.top) ? box_a.top : box_b.top;

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      I_OV: begin
        mul_x = 18'(ow);
        mul_y = 18'(oh);
      end
      I_AA: begin
        mul_x = 18'(wa);
        mul_y = 18'(ha);
      end
      I_AB: begin
        mul_x = 18'(wb);
        mul_y = 18'(hb);
      end
      I_LO: begin
        mul_x = $signed({1'b0, uni[16:0]});
        mul_y = $signed({2'b00, thr});
      end
      I_HI: begin
        mul_x = $signed({1'b0, uni[33:17]});
        mul_y = $signed({2'b00, thr});
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p = mul_x * mul_y;

  assign no_ov  = (ow <= 17'sd0) || (oh <= 17'sd0);
  assign no_uni = (uni <= 36'sd0);
  // overlap*65536 against threshold*union, union split in two halves
  assign lhs = {4'b0, ov[31:0], 16'b0};
  assign rhs = {17'b0, plo[34:0]} + {phi[34:0], 17'b0};

  assign res.done = ((state == I_OV) && no_ov) || ((state == I_LO) && no_uni) ||
                    (state == I_CMP);
  assign res.suppress = (state == I_CMP) && (lhs > rhs);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
    end else begin
      unique case (state)
        I_IDLE: if (start) state <= I_OV;
        I_OV:   state <= no_ov ? I_IDLE : I_AA;
        I_AA:   state <= I_AB;
        I_AB:   state <= I_UNI;
        I_UNI:  state <= I_LO;
        I_LO:   state <= no_uni ? I_IDLE : I_HI;
        I_HI:   state <= I_CMP;
        I_CMP:  state <= I_IDLE;
        default: state <= I_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == I_IDLE && start) begin
      ow <= $signed({1'b0, min_r}) - $signed({1'b0, max_l});
      oh <= $signed({1'b0, min_b}) - $signed({1'b0, max_t});
      wa <= $signed({1'b0, box_a.right}) - $signed({1'b0, box_a.left});
      ha <= $signed({1'b0, box_a.bottom}) - $signed({1'b0, box_a.top});
      wb <= $signed({1'b0, box_b.right}) - $signed({1'b0, box_b.left});
      hb <= $signed({1'b0, box_b.bottom}) - $signed({1'b0, box_b.top});
    end
    if (state == I_OV) ov <= mul_p;
    if (state == I_AA) aa <= mul_p;
    if (state == I_AB) ab <= mul_p;
    if (state == I_UNI) uni <= aa + ab - ov;
    if (state == I_LO) plo <= mul_p;
    if (state == I_HI) phi <= mul_p;
  end

endmodule

// ===== hw/rtl/per_class_box_nms.sv =====
// per-class greedy box suppression: loader, ranking, suppression sequencer
//
//   channel | direction | words
//   in      | in        | one detection box per word, final_box closes the set
//   out     | out       | one kept box per word, last_result closes the set
//   cfg     | in        | register write, index and data, no wait
//
// loading takes one box per cycle; after the final box the block ranks the n
// stored boxes by comparing each score with every stored score, then tests
// each box against the kept boxes of its class, one pair at a time on the
// shared multiplier of the overlap unit.
// reset clears the box count, the drop flag and the sequencer; the stores
// need no clearing pass. in_stall stays high from the final box until the
// last result word has been handed to the output register.
module per_class_box_nms #(
  parameter int MAX_BOXES   = pcnms_pkg::MAX_BOXES_DEF,
  parameter int MAX_CLASSES = pcnms_pkg::MAX_CLASSES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] left_x,
  input  logic [15:0] top_y,
  input  logic [15:0] right_x,
  input  logic [15:0] bottom_y,
  input  logic [15:0] confidence,
  input  logic [3:0]  class_id,
  input  logic        final_box,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_left_x,
  output logic [15:0] out_top_y,
  output logic [15:0] out_right_x,
  output logic [15:0] out_bottom_y,
  output logic [15:0] out_confidence,
  output logic [3:0]  out_class_id,
  output logic        last_result,
  output logic        no_boxes,
  output logic        dropped_flag,
  // configuration
  input  logic                              cfg_write,
  input  logic [pcnms_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcnms_pkg::CFG_W-1:0]       cfg_data
);

  localparam int IW  = $clog2(MAX_BOXES);
  localparam int CW  = $clog2(MAX_BOXES + 1);
  localparam int CCW = $clog2(MAX_CLASSES + 1);

  typedef enum logic [15:0] {
    S_LOAD    = 16'h0001,
    S_RK_I    = 16'h0002,
    S_RK_IW   = 16'h0004,
    S_RK_JR   = 16'h0008,
    S_RK_JW   = 16'h0010,
    S_CL_ST   = 16'h0020,
    S_CL_RANK = 16'h0040,
    S_CL_BOX  = 16'h0080,
    S_CL_CHK  = 16'h0100,
    S_KP_IDX  = 16'h0200,
    S_KP_BOX  = 16'h0400,
    S_KP_IOU  = 16'h0800,
    S_KP_WAIT = 16'h1000,
    S_KEEP    = 16'h2000,
    S_EM_IDX  = 16'h4000,
    S_EM_OUT  = 16'h8000
  } state_t;

  // emission needs one more step: read box after reading kept index
  state_t state;
  logic   em_box_rd;

  // config registers
  logic [15:0] iou_thr;
  logic [4:0]  class_count;
  logic [CCW-1:0] limit;

  // sequencer registers
  logic [CW-1:0]  box_count;
  logic           drop_seen;
  logic [CW-1:0]  i, j, kcnt, kj, ej;
  logic [IW-1:0]  rank_cnt;
  logic [15:0]    score_i;
  logic [CCW-1:0] c;
  logic           fin;
  pcnms_pkg::box_t cand;

  // one result held back until it is known whether another follows
  pcnms_pkg::box_t held;
  logic            held_valid;

  // memories
  logic            box_we;
  logic [IW-1:0]   box_raddr;
  pcnms_pkg::box_t box_wdata, box_rdata;
  logic            rank_we;
  logic [IW-1:0]   rank_rdata;
  logic            kept_we;
  logic [IW-1:0]   kept_raddr, kept_rdata;

  pcnms_pkg::iou_res_t iou_res;

  // rank including the compare done in the final scan cycle
  logic           beats;
  logic [IW-1:0]  rank_final;
  logic [IW-1:0]  cand_idx;

  logic in_acc, store_ok, out_free, out_load;

  assign limit = (32'(class_count) > MAX_CLASSES) ? CCW'(MAX_CLASSES) : CCW'(class_count);

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign store_ok = (32'(box_count) < MAX_BOXES) && (32'(class_id) < 32'(limit));
  assign out_free = !out_valid || !out_stall;

  // output register takes a word: closing word, or a held box pushed out by the next one
  assign out_load = (state == S_EM_OUT) && out_free && (fin || (em_box_rd && held_valid));

  assign box_we    = in_acc && store_ok;
  assign box_wdata = '{cls: class_id, score: confidence, bottom: bottom_y, right: right_x,
                       top: top_y, left: left_x};

  // box store read address by phase
  always_comb begin
    unique case (state)
      S_RK_I:   box_raddr = i[IW-1:0];
      S_RK_JR:  box_raddr = j[IW-1:0];
      S_CL_BOX: box_raddr = rank_rdata;
      S_KP_BOX: box_raddr = kept_rdata;
      default:  box_raddr = kept_rdata;
    endcase
  end

  assign beats = (box_rdata.score > score_i) ||
                 ((box_rdata.score == score_i) && (j < i));
  assign rank_final = beats ? rank_cnt + IW'(1) : rank_cnt;

  assign rank_we    = (state == S_RK_JW) && (32'(j) + 1 == 32'(box_count));
  assign kept_we    = (state == S_KEEP);
  // emission keeps the kept index steady while the output waits
  assign kept_raddr = (state == S_EM_IDX || state == S_EM_OUT) ? ej[IW-1:0] : kj[IW-1:0];

  pcnms_ram #(.WIDTH(pcnms_pkg::BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk  (clk),
    .we   (box_we),
    .waddr(box_count[IW-1:0]),
    .wdata(box_wdata),
    .raddr(box_raddr),
    .rdata(box_rdata)
  );

  // rank_order: sorted position -> box index
  pcnms_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_rank_ram (
    .clk  (clk),
    .we   (rank_we),
    .waddr(rank_final),
    .wdata(i[IW-1:0]),
    .raddr(i[IW-1:0]),
    .rdata(rank_rdata)
  );

  // kept list of the current class, in score order
  pcnms_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_kept_ram (
    .clk  (clk),
    .we   (kept_we),
    .waddr(kcnt[IW-1:0]),
    .wdata(cand_idx),
    .raddr(kept_raddr),
    .rdata(kept_rdata)
  );

  pcnms_iou u_iou (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_KP_IOU),
    .box_a  (cand),
    .box_b  (box_rdata),
    .thr    (iou_thr),
    .res    (iou_res)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      iou_thr     <= pcnms_pkg::IOU_THR_RESET;
      class_count <= pcnms_pkg::CLASS_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pcnms_pkg::REG_IOU_THR:     iou_thr <= cfg_data;
        pcnms_pkg::REG_CLASS_COUNT: class_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // output word valid: set on load, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      box_count  <= '0;
      drop_seen  <= 1'b0;
      held_valid <= 1'b0;
      em_box_rd  <= 1'b0;
      fin        <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (store_ok) box_count <= box_count + CW'(1);
            else drop_seen <= 1'b1;
            if (final_box) begin
              i     <= '0;
              state <= S_RK_I;
            end
          end
        end
        S_RK_I: begin
          if (i == box_count) begin
            c     <= '0;
            state <= S_CL_ST;
          end else begin
            state <= S_RK_IW;
          end
        end
        S_RK_IW: begin
          score_i  <= box_rdata.score;
          j        <= '0;
          rank_cnt <= '0;
          state    <= S_RK_JR;
        end
        S_RK_JR: state <= S_RK_JW;
        S_RK_JW: begin
          rank_cnt <= rank_final;
          if (32'(j) + 1 == 32'(box_count)) begin
            i     <= i + CW'(1);
            state <= S_RK_I;
          end else begin
            j     <= j + CW'(1);
            state <= S_RK_JR;
          end
        end
        S_CL_ST: begin
          if (c == limit) begin
            fin   <= 1'b1;
            state <= S_EM_OUT;
          end else begin
            i     <= '0;
            kcnt  <= '0;
            state <= S_CL_RANK;
          end
        end
        S_CL_RANK: begin
          if (i == box_count) begin
            ej    <= '0;
            state <= S_EM_IDX;
          end else begin
            state <= S_CL_BOX;
          end
        end
        S_CL_BOX: begin
          cand_idx <= rank_rdata;
          state    <= S_CL_CHK;
        end
        S_CL_CHK: begin
          cand <= box_rdata;
          if (32'(box_rdata.cls) != 32'(c)) begin
            i     <= i + CW'(1);
            state <= S_CL_RANK;
          end else if (kcnt == '0) begin
            state <= S_KEEP;
          end else begin
            kj    <= '0;
            state <= S_KP_IDX;
          end
        end
        S_KP_IDX: state <= S_KP_BOX;
        S_KP_BOX: state <= S_KP_IOU;
        S_KP_IOU: state <= S_KP_WAIT;
        S_KP_WAIT: begin
          if (iou_res.done) begin
            if (iou_res.suppress) begin
              i     <= i + CW'(1);
              state <= S_CL_RANK;
            end else if (kj + CW'(1) == kcnt) begin
              state <= S_KEEP;
            end else begin
              kj    <= kj + CW'(1);
              state <= S_KP_IDX;
            end
          end
        end
        S_KEEP: begin
          kcnt  <= kcnt + CW'(1);
          i     <= i + CW'(1);
          state <= S_CL_RANK;
        end
        S_EM_IDX: begin
          if (ej == kcnt) begin
            c     <= c + CCW'(1);
            state <= S_CL_ST;
          end else begin
            em_box_rd <= 1'b0;
            state     <= S_EM_OUT;
          end
        end
        S_EM_OUT: begin
          if (fin) begin
            // close the set: held result or the empty word, flagged last
            if (out_free) begin
              out_left_x     <= held_valid ? held.left : '0;
              out_top_y      <= held_valid ? held.top : '0;
              out_right_x    <= held_valid ? held.right : '0;
              out_bottom_y   <= held_valid ? held.bottom : '0;
              out_confidence <= held_valid ? held.score : '0;
              out_class_id   <= held_valid ? held.cls : '0;
              last_result    <= 1'b1;
              no_boxes       <= !held_valid;
              dropped_flag   <= drop_seen;
              held_valid     <= 1'b0;
              fin            <= 1'b0;
              box_count      <= '0;
              drop_seen      <= 1'b0;
              state          <= S_LOAD;
            end
          end else if (!em_box_rd) begin
            // box read issued this cycle from the kept index
            em_box_rd <= 1'b1;
          end else if (!held_valid) begin
            held       <= box_rdata;
            held_valid <= 1'b1;
            ej         <= ej + CW'(1);
            state      <= S_EM_IDX;
          end else if (out_free) begin
            out_left_x     <= held.left;
            out_top_y      <= held.top;
            out_right_x    <= held.right;
            out_bottom_y   <= held.bottom;
            out_confidence <= held.score;
            out_class_id   <= held.cls;
            last_result    <= 1'b0;
            no_boxes       <= 1'b0;
            dropped_flag   <= drop_seen;
            held           <= box_rdata;
            ej             <= ej + CW'(1);
            state          <= S_EM_IDX;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== sim/per_class_box_nms_checker.sv =====
// checker for per_class_box_nms: predicts kept boxes per set and compares output words
module per_class_box_nms_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] left_x,
  input  logic [15:0] top_y,
  input  logic [15:0] right_x,
  input  logic [15:0] bottom_y,
  input  logic [15:0] confidence,
  input  logic [3:0]  class_id,
  input  logic        final_box,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_left_x,
  input  logic [15:0] out_top_y,
  input  logic [15:0] out_right_x,
  input  logic [15:0] out_bottom_y,
  input  logic [15:0] out_confidence,
  input  logic [3:0]  out_class_id,
  input  logic        last_result,
  input  logic        no_boxes,
  input  logic        dropped_flag,
  input  logic        cfg_write,
  input  logic [pcnms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcnms_pkg::CFG_W-1:0]     cfg_data,
  output int          errors,
  output int          pending
);

  localparam int CAP = pcnms_pkg::MAX_BOXES_DEF;
  localparam int CLS_CAP = pcnms_pkg::MAX_CLASSES_DEF;

  typedef struct packed {
    pcnms_pkg::box_t bx;
    logic last;
    logic none;
    logic drop;
  } kept_word_t;

  kept_word_t      kept_q[$];
  pcnms_pkg::box_t held[CAP];
  int              held_n;
  logic            drop_pending;
  logic [15:0]     thr;
  logic [4:0]      n_classes;

  assign pending = kept_q.size();

  function automatic bit overlap_exceeds(pcnms_pkg::box_t a, pcnms_pkg::box_t b,
                                         logic [15:0] t);
    longint ow, oh, ov, un;
    ow = ((a.right < b.right) ? longint'(a.right) : longint'(b.right)) -
         ((a.left > b.left) ? longint'(a.left) : longint'(b.left));
    oh = ((a.bottom < b.bottom) ? longint'(a.bottom) : longint'(b.bottom)) -
         ((a.top > b.top) ? longint'(a.top) : longint'(b.top));
    if (ow <= 0 || oh <= 0) return 0;
    ov = ow * oh;
    un = (longint'(a.right) - longint'(a.left)) * (longint'(a.bottom) - longint'(a.top)) +
         (longint'(b.right) - longint'(b.left)) * (longint'(b.bottom) - longint'(b.top)) - ov;
    if (un <= 0) return 0;
    return ov * 65536 > longint'(t) * un;
  endfunction

  // greedy suppression over the held set, queues the expected words
  task automatic close_set();
    int   rank[$];
    bit   kept[CAP];
    int   pos, emitted;
    kept_word_t w;
    int   lim;
    lim = (n_classes > CLS_CAP) ? CLS_CAP : n_classes;
    emitted = 0;
    // stable order by falling score
    for (int i = 0; i < held_n; i++) begin
      pos = rank.size();
      while (pos > 0 && held[rank[pos-1]].score < held[i].score) pos--;
      rank.insert(pos, i);
    end
    for (int i = 0; i < CAP; i++) kept[i] = 0;
    for (int c = 0; c < lim; c++) begin
      for (int i = 0; i < held_n; i++) begin
        if (held[rank[i]].cls == c) begin
          kept[rank[i]] = 1;
          for (int j = 0; j < i; j++)
            if (held[rank[j]].cls == c && kept[rank[j]] &&
                overlap_exceeds(held[rank[i]], held[rank[j]], thr))
              kept[rank[i]] = 0;
        end
      end
      for (int i = 0; i < held_n; i++) begin
        if (held[rank[i]].cls == c && kept[rank[i]]) begin
          w = '0;
          w.bx = held[rank[i]];
          w.drop = drop_pending;
          kept_q.insert(kept_q.size(), w);
          emitted++;
        end
      end
    end
    if (emitted == 0) begin
      w = '0;
      w.none = 1;
      w.drop = drop_pending;
      kept_q.insert(kept_q.size(), w);
    end
    kept_q[kept_q.size()-1].last = 1;
    held_n = 0;
    drop_pending = 0;
  endtask

  task automatic report(string what, longint want, longint got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_n = 0;
      drop_pending = 0;
      thr = pcnms_pkg::IOU_THR_RESET;
      n_classes = pcnms_pkg::CLASS_COUNT_RESET;
      errors = 0;
      kept_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == pcnms_pkg::REG_IOU_THR) thr = cfg_data;
        else if (cfg_index == pcnms_pkg::REG_CLASS_COUNT) n_classes = cfg_data[4:0];
      end
      if (in_valid && !in_stall) begin
        if (held_n < CAP && class_id < ((n_classes > CLS_CAP) ? CLS_CAP : n_classes)) begin
          held[held_n] = '{cls: class_id, score: confidence, bottom: bottom_y,
                           right: right_x, top: top_y, left: left_x};
          held_n = held_n + 1;
        end else begin
          drop_pending = 1;
        end
        if (final_box) close_set();
      end
      if (out_valid && !out_stall) begin
        if (kept_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output word at %0t", $realtime);
        end else begin
          kept_word_t w;
          w = kept_q.pop_front();
          if (out_left_x !== w.bx.left) report("out_left_x", w.bx.left, out_left_x);
          if (out_top_y !== w.bx.top) report("out_top_y", w.bx.top, out_top_y);
          if (out_right_x !== w.bx.right) report("out_right_x", w.bx.right, out_right_x);
          if (out_bottom_y !== w.bx.bottom) report("out_bottom_y", w.bx.bottom, out_bottom_y);
          if (out_confidence !== w.bx.score)
            report("out_confidence", w.bx.score, out_confidence);
          if (out_class_id !== w.bx.cls) report("out_class_id", w.bx.cls, out_class_id);
          if (last_result !== w.last) report("last_result", w.last, last_result);
          if (no_boxes !== w.none) report("no_boxes", w.none, no_boxes);
          if (dropped_flag !== w.drop) report("dropped_flag", w.drop, dropped_flag);
        end
      end
    end
  end
endmodule

// ===== sim/tb_per_class_box_nms.sv =====
// testbench top for per_class_box_nms: stimulus, output stalls and verdict
module tb_per_class_box_nms;

  // indices past the register list, the block must ignore them
  localparam logic [pcnms_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [pcnms_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int RANDOM_ITEMS = 335;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [15:0] left_x = 0, top_y = 0, right_x = 0, bottom_y = 0, confidence = 0;
  logic [3:0]  class_id = 0;
  logic        final_box = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_left_x, out_top_y, out_right_x, out_bottom_y, out_confidence;
  logic [3:0]  out_class_id;
  logic        last_result, no_boxes, dropped_flag;
  logic        cfg_write = 0;
  logic [pcnms_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pcnms_pkg::CFG_W-1:0]     cfg_data = '0;
  int          errors;
  int          pending;
  bit          stim_done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  per_class_box_nms dut (.*);
  per_class_box_nms_checker chk (.*);

  // mostly back to back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one detection word; valid stays high when the next word follows directly
  task automatic send_box(logic [15:0] l, logic [15:0] t, logic [15:0] r,
                          logic [15:0] b, logic [15:0] s, logic [3:0] c, logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    left_x = l; top_y = t; right_x = r; bottom_y = b;
    confidence = s; class_id = c; final_box = fin;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // register writes only with the block drained
  task automatic write_reg(logic [pcnms_pkg::CFG_IDX_W-1:0] idx,
                           logic [pcnms_pkg::CFG_W-1:0] val);
    in_valid = 0;
    wait (pending == 0);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_write = 1;
    @(negedge clk);
    cfg_write = 0;
  endtask

  // random box, clustered so that overlaps are common
  task automatic send_random_box(int cls_hi, logic fin, int cx, int cy);
    logic [15:0] l, t, r, b;
    if ($urandom_range(0, 9) == 0) begin
      // full range corners, ordered or not
      l = 16'($urandom); t = 16'($urandom); r = 16'($urandom); b = 16'($urandom);
    end else begin
      l = 16'(cx + $urandom_range(0, 60));
      t = 16'(cy + $urandom_range(0, 60));
      r = 16'(l + $urandom_range(1, 200));
      b = 16'(t + $urandom_range(1, 200));
    end
    send_box(l, t, r, b, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom),
             4'($urandom_range(0, cls_hi)), fin);
  endtask

  // output side stall pattern: quiet stretches, short bursts and a few long holds
  initial begin
    int mode, len;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 9);
      len = $urandom_range(5, 60);
      repeat (len) begin
        if (mode < 3) out_stall = 0;
        else if (mode < 9) out_stall = ($urandom_range(0, 3) == 0);
        else out_stall = 1;
        @(negedge clk);
      end
    end
  end

  initial begin
    int sent, set_len, cls_hi, cx, cy;
    repeat (2) @(negedge clk);
    rst = 0;

    // defaults: one class, threshold 0.45
    // extreme corners and score, kept alone
    send_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 1'b1);
    // tie on score keeps arrival order, duplicate suppressed, class out of range dropped
    send_box(16'd100, 16'd100, 16'd200, 16'd200, 16'd500, 4'd0, 1'b0);
    send_box(16'd100, 16'd100, 16'd200, 16'd200, 16'd500, 4'd0, 1'b0);
    send_box(16'd300, 16'd300, 16'd400, 16'd400, 16'd500, 4'd0, 1'b0);
    send_box(16'd100, 16'd100, 16'd200, 16'd200, 16'd900, 4'd1, 1'b1);
    // nothing kept: the only box has an unknown class
    send_box(16'd10, 16'd10, 16'd20, 16'd20, 16'd7, 4'd5, 1'b1);
    // zero width and inverted boxes never count as overlapping
    send_box(16'd50, 16'd50, 16'd50, 16'd80, 16'd40, 4'd0, 1'b0);
    send_box(16'd50, 16'd50, 16'd50, 16'd80, 16'd30, 4'd0, 1'b0);
    send_box(16'd200, 16'd200, 16'd100, 16'd100, 16'd20, 4'd0, 1'b0);
    send_box(16'd200, 16'd200, 16'd100, 16'd100, 16'd0, 4'd0, 1'b1);

    // any overlap suppresses at threshold zero; all classes in use
    write_reg(pcnms_pkg::REG_IOU_THR, 16'd0);
    write_reg(pcnms_pkg::REG_CLASS_COUNT, 16'd16);
    send_box(16'd0, 16'd0, 16'd100, 16'd100, 16'd800, 4'd15, 1'b0);
    send_box(16'd99, 16'd99, 16'd300, 16'd300, 16'd700, 4'd15, 1'b0);
    send_box(16'd0, 16'd0, 16'd100, 16'd100, 16'd600, 4'd0, 1'b0);
    send_box(16'd100, 16'd0, 16'd200, 16'd100, 16'd650, 4'd0, 1'b1);

    // at the top threshold identical boxes are still suppressed
    write_reg(pcnms_pkg::REG_IOU_THR, 16'hFFFF);
    send_box(16'd40, 16'd40, 16'd90, 16'd90, 16'd10, 4'd3, 1'b0);
    send_box(16'd40, 16'd40, 16'd90, 16'd90, 16'd10, 4'd3, 1'b0);
    send_box(16'd40, 16'd40, 16'd91, 16'd90, 16'd20, 4'd3, 1'b1);

    // class count of zero drops everything; stray indices ignored
    write_reg(pcnms_pkg::REG_CLASS_COUNT, 16'd0);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h5555);
    send_box(16'd1, 16'd1, 16'd9, 16'd9, 16'd100, 4'd0, 1'b1);

    // class count above the cap acts as the cap; overfill the store
    write_reg(pcnms_pkg::REG_CLASS_COUNT, 16'd31);
    write_reg(pcnms_pkg::REG_IOU_THR, pcnms_pkg::IOU_THR_RESET);
    for (int i = 0; i < 67; i++)
      send_random_box(15, i == 66, 1000, 1000);

    // random phases through several settings
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0: write_reg(pcnms_pkg::REG_IOU_THR, 16'($urandom));
        1: write_reg(pcnms_pkg::REG_IOU_THR, 16'($urandom_range(16000, 50000)));
        2: write_reg(pcnms_pkg::REG_CLASS_COUNT, 16'($urandom_range(1, 16)));
        3: write_reg(pcnms_pkg::REG_CLASS_COUNT, 16'($urandom_range(0, 31)));
        default: ;
      endcase
      cls_hi = $urandom_range(0, 3);
      for (int k = 0; k < 4 && sent < RANDOM_ITEMS; k++) begin
        set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 35) : $urandom_range(1, 8);
        cx = $urandom_range(0, 60000);
        cy = $urandom_range(0, 60000);
        for (int i = 0; i < set_len; i++) begin
          // occasionally a class past the count, to be dropped
          send_random_box(($urandom_range(0, 19) == 0) ? 15 : cls_hi, i == set_len - 1, cx, cy);
          sent++;
        end
      end
    end

    in_valid = 0;
    stim_done = 1;
  end

  // verdict once every expected word has come out
  initial begin
    wait (stim_done);
    wait (pending == 0);
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("tb_per_class_box_nms: clean");
    else
      $display("tb_per_class_box_nms: errors");
    $finish;
  end

  initial begin
    #20000000;
    $display("tb_per_class_box_nms: errors");
    $finish;
  end
endmodule
